// ----- src/mse_pkg.sv -----
package mse_pkg;

   localparam int MSE_DEPTH = 64;
   localparam int DATA_W = 32;

   typedef struct packed {
      logic cur_src_b;
      logic wr_en;
      logic done;
      logic res_b;
   } mse_ctl_type;

endpackage

// ----- src/merge_sort_engine.sv -----
// Stable ascending sort of signed 32-bit items, up to DEPTH of them per set. Items are
// loaded one per cycle while req_stall is low; an item with req_last set closes the set
// (items past DEPTH are dropped, but a dropped last item still closes it). The set is
// then sorted by bottom-up merge passes that ping-pong between two memories with one
// write and two read ports, one element per cycle. Results leave through a single output
// register fed by the memory's registered read port; a new read is issued only once the
// previous item has reached that register. The final one carries rsp_final_res. A new set
// may be loaded while the last result is still held.
module merge_sort_engine import mse_pkg::*; #(
   parameter int DEPTH = MSE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_sorted_value,
   output logic                     rsp_final_res
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SORT,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] e_ff, e_in;
   logic             start_ff, start_in;
   logic             pend_ff, pend_in;
   logic             fin_pend_ff, fin_pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic             rsp_final_ff, rsp_final_in;

   logic signed [DATA_W-1:0] mem_a [DEPTH];
   logic signed [DATA_W-1:0] mem_b [DEPTH];
   logic signed [DATA_W-1:0] a_rd0_ff, a_rd1_ff, b_rd0_ff, b_rd1_ff;

   logic                     req_accept, load_we, issue;
   logic [CNT_W-1:0]         count_inc, e_inc;
   logic                     we_a, we_b;
   logic [ADDR_W-1:0]        waddr_a, raddr0, raddr1;
   logic signed [DATA_W-1:0] wdata_a;

   logic [ADDR_W-1:0]        mc_rd_addr_left, mc_rd_addr_right, mc_wr_addr;
   logic signed [DATA_W-1:0] mc_wr_data, mc_rd_left, mc_rd_right, emit_data;
   mse_ctl_type              ctl;

   mse_merge_ctrl #(
      .DEPTH(DEPTH)
   ) u_merge_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start_ff),
      .count         (n_ff),
      .rd_left       (mc_rd_left),
      .rd_right      (mc_rd_right),
      .rd_addr_left  (mc_rd_addr_left),
      .rd_addr_right (mc_rd_addr_right),
      .wr_addr       (mc_wr_addr),
      .wr_data       (mc_wr_data),
      .ctl           (ctl)
   );

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign load_we    = req_accept && (count_ff < CNT_W'(DEPTH));
   assign count_inc  = count_ff + CNT_W'(1);
   assign e_inc      = e_ff + CNT_W'(1);
   assign issue      = (state_ff == ST_EMIT) && !pend_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      n_in        = n_ff;
      e_in        = e_ff;
      start_in    = 1'b0;
      pend_in     = issue;
      fin_pend_in = fin_pend_ff;
      case (state_ff)
         ST_LOAD: begin
            if (load_we) begin
               count_in = count_inc;
            end
            if (req_accept && req_last) begin
               n_in     = load_we ? count_inc : count_ff;
               start_in = 1'b1;
               state_in = ST_SORT;
            end
         end
         ST_SORT: begin
            if (ctl.done) begin
               e_in     = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (issue) begin
               e_in        = e_inc;
               fin_pend_in = (e_inc == n_ff);
               if (e_inc == n_ff) begin
                  count_in = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign emit_data = ctl.res_b ? b_rd0_ff : a_rd0_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_final_in = rsp_final_ff;
      if (pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = emit_data;
         rsp_final_in = fin_pend_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         start_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      e_ff         <= e_in;
      fin_pend_ff  <= fin_pend_in;
      rsp_value_ff <= rsp_value_in;
      rsp_final_ff <= rsp_final_in;
   end

   // memory ports: a takes loads and odd-pass merges, b takes even-pass merges
   assign we_a    = load_we || (ctl.wr_en && ctl.cur_src_b);
   assign we_b    = ctl.wr_en && !ctl.cur_src_b;
   assign waddr_a = (state_ff == ST_LOAD) ? count_ff[ADDR_W-1:0] : mc_wr_addr;
   assign wdata_a = (state_ff == ST_LOAD) ? req_value : mc_wr_data;
   assign raddr0  = (state_ff == ST_EMIT) ? e_ff[ADDR_W-1:0] : mc_rd_addr_left;
   assign raddr1  = mc_rd_addr_right;

   // read with forwarding of a same-cycle write to the same entry
   always_ff @(posedge clock) begin
      if (we_a) begin
         mem_a[waddr_a] <= wdata_a;
      end
      a_rd0_ff <= (we_a && (waddr_a == raddr0)) ? wdata_a : mem_a[raddr0];
      a_rd1_ff <= (we_a && (waddr_a == raddr1)) ? wdata_a : mem_a[raddr1];
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         mem_b[mc_wr_addr] <= mc_wr_data;
      end
      b_rd0_ff <= (we_b && (mc_wr_addr == raddr0)) ? mc_wr_data : mem_b[raddr0];
      b_rd1_ff <= (we_b && (mc_wr_addr == raddr1)) ? mc_wr_data : mem_b[raddr1];
   end

   assign mc_rd_left  = ctl.cur_src_b ? b_rd0_ff : a_rd0_ff;
   assign mc_rd_right = ctl.cur_src_b ? b_rd1_ff : a_rd1_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_final_res    = rsp_final_ff;

`ifndef ASSERT_OFF
   a_pend_slot_free: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !rsp_valid_ff)
      else $error("read data returned while output register still occupied");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count beyond depth");

   a_merge_in_sort: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |-> (state_ff == ST_SORT))
      else $error("merge write outside sort phase");

   a_done_in_sort: assert property (@(posedge clock) disable iff (reset)
      ctl.done |-> (state_ff == ST_SORT))
      else $error("sort done outside sort phase");

   a_emit_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT) && (state_in == ST_EMIT) |=> (e_ff == '0) && !pend_ff)
      else $error("emit started without clean index");
`endif

endmodule

// ----- src/mse_merge_ctrl.sv -----
module mse_merge_ctrl import mse_pkg::*; #(
   parameter int DEPTH = MSE_DEPTH,
   localparam int ADDR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [CNT_W-1:0]         count,
   input  logic signed [DATA_W-1:0] rd_left,
   input  logic signed [DATA_W-1:0] rd_right,
   output logic [ADDR_W-1:0]        rd_addr_left,
   output logic [ADDR_W-1:0]        rd_addr_right,
   output logic [ADDR_W-1:0]        wr_addr,
   output logic signed [DATA_W-1:0] wr_data,
   output mse_ctl_type              ctl
);

   localparam int W_W = CNT_W + 1;
   localparam int SUM_W = CNT_W + 2;

   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CNT_W-1:0] mid_ff, mid_in, hi_ff, hi_in;
   logic [W_W-1:0]   w_ff, w_in;
   logic             pass_ff, pass_in;
   logic             done_ff, done_in;
   logic             res_b_ff, res_b_in;

   logic             take_left;
   logic [CNT_W-1:0] k_next;
   logic             seg_end, pass_end, finish;
   logic [W_W-1:0]   w_dbl, w_new;
   logic [CNT_W-1:0] lo_new;
   logic [SUM_W-1:0] mid_sum, hi_sum, n_ext;

   assign take_left = (j_ff >= hi_ff) || ((i_ff < mid_ff) && (rd_left <= rd_right));
   assign wr_data   = take_left ? rd_left : rd_right;
   assign k_next    = k_ff + CNT_W'(1);
   assign seg_end   = (k_next == hi_ff);
   assign pass_end  = seg_end && (hi_ff == count);
   assign w_dbl     = {w_ff[W_W-2:0], 1'b0};
   assign finish    = pass_end && (w_dbl >= W_W'(count));

   // base and run width of the next pair of runs
   always_comb begin
      if (state_ff == ST_IDLE) begin
         lo_new = '0;
         w_new  = W_W'(1);
      end else begin
         lo_new = pass_end ? '0 : hi_ff;
         w_new  = pass_end ? w_dbl : w_ff;
      end
   end

   assign n_ext   = SUM_W'(count);
   assign mid_sum = SUM_W'(lo_new) + SUM_W'(w_new);
   assign hi_sum  = mid_sum + SUM_W'(w_new);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      mid_in   = mid_ff;
      hi_in    = hi_ff;
      w_in     = w_ff;
      pass_in  = pass_ff;
      done_in  = 1'b0;
      res_b_in = res_b_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               res_b_in = 1'b0;
               if (count <= CNT_W'(1)) begin
                  done_in = 1'b1;
               end else begin
                  state_in = ST_MERGE;
                  pass_in  = 1'b0;
                  w_in     = w_new;
                  k_in     = lo_new;
                  i_in     = lo_new;
                  mid_in   = (mid_sum > n_ext) ? count : mid_sum[CNT_W-1:0];
                  j_in     = mid_in;
                  hi_in    = (hi_sum > n_ext) ? count : hi_sum[CNT_W-1:0];
               end
            end
         end
         ST_MERGE: begin
            k_in = k_next;
            if (take_left) begin
               i_in = i_ff + CNT_W'(1);
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
            if (seg_end) begin
               if (finish) begin
                  state_in = ST_IDLE;
                  done_in  = 1'b1;
                  res_b_in = ~pass_ff;
               end else begin
                  pass_in = pass_end ? ~pass_ff : pass_ff;
                  w_in    = w_new;
                  k_in    = lo_new;
                  i_in    = lo_new;
                  mid_in  = (mid_sum > n_ext) ? count : mid_sum[CNT_W-1:0];
                  j_in    = mid_in;
                  hi_in   = (hi_sum > n_ext) ? count : hi_sum[CNT_W-1:0];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         res_b_ff <= 1'b0;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         res_b_ff <= res_b_in;
         pass_ff  <= pass_in;
      end
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      mid_ff <= mid_in;
      hi_ff  <= hi_in;
      w_ff   <= w_in;
   end

   // read addresses follow the next index so data lines up with the current one
   assign rd_addr_left  = i_in[ADDR_W-1:0];
   assign rd_addr_right = j_in[ADDR_W-1:0];
   assign wr_addr       = k_ff[ADDR_W-1:0];

   assign ctl.cur_src_b = pass_ff;
   assign ctl.wr_en     = (state_ff == ST_MERGE);
   assign ctl.done      = done_ff;
   assign ctl.res_b     = res_b_ff;

endmodule
